[sv/abip_pkg.sv]
// Shared types and constants for the auto-base integer parser.
// Scan phase codes, character constants and the decoded character record.
// No dependencies.
package abip_pkg;

  localparam int unsigned ValueW = 64;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChLowX  = 8'h78;

  // Letter digits: 'a' - 10 and 'A' - 10
  localparam logic [7:0] LowHexBias = 8'h57;
  localparam logic [7:0] UpHexBias  = 8'h37;

  typedef enum logic [6:0] {
    PH_BLANK1 = 7'b000_0001,
    PH_BLANK2 = 7'b000_0010,
    PH_ZERO   = 7'b000_0100,
    PH_DEC    = 7'b000_1000,
    PH_OCT    = 7'b001_0000,
    PH_HEX    = 7'b010_0000,
    PH_DONE   = 7'b100_0000
  } phase_t;

  typedef struct packed {
    logic       blank;
    logic       sign;
    logic       minus;
    logic       zero;
    logic       dec;
    logic       oct;
    logic       hex_x;
    logic       hex;
    logic [3:0] digit;
  } char_class_t;

endpackage

[sv/abip_ifs.sv]
// Valid/ready channel interfaces for the auto-base integer parser.
// Character channel in, value channel out. Depends on abip_pkg.
interface abip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface abip_value_if;
  logic                                valid;
  logic                                ready;
  logic signed [abip_pkg::ValueW-1:0]  parsed_value;

  modport source (output valid, output parsed_value, input ready);
  modport sink   (input valid, input parsed_value, output ready);
endinterface

[sv/abip_decode.sv]
// Character classifier: blank, sign, digit classes and digit value.
// Pure combinational. Depends on abip_pkg.
module abip_decode (
  input  logic [7:0]             char_code,
  output abip_pkg::char_class_t  cls
);

  logic is_low_hex;
  logic is_up_hex;
  logic [7:0] dig_full;

  always_comb begin
    is_low_hex = char_code inside {[abip_pkg::ChLowA:abip_pkg::ChLowF]};
    is_up_hex  = char_code inside {[abip_pkg::ChUpA:abip_pkg::ChUpF]};

    cls.blank = (char_code == abip_pkg::ChSpace) || (char_code == abip_pkg::ChTab);
    cls.minus = (char_code == abip_pkg::ChMinus);
    cls.sign  = cls.minus || (char_code == abip_pkg::ChPlus);
    cls.zero  = (char_code == abip_pkg::ChZero);
    cls.dec   = char_code inside {[abip_pkg::ChZero:abip_pkg::ChNine]};
    cls.oct   = char_code inside {[abip_pkg::ChZero:abip_pkg::ChSeven]};
    cls.hex_x = (char_code == abip_pkg::ChLowX) || (char_code == abip_pkg::ChUpX);
    cls.hex   = cls.dec || is_low_hex || is_up_hex;

    if (is_low_hex) begin
      dig_full = char_code - abip_pkg::LowHexBias;
    end else if (is_up_hex) begin
      dig_full = char_code - abip_pkg::UpHexBias;
    end else begin
      dig_full = char_code - abip_pkg::ChZero;
    end
    cls.digit = dig_full[3:0];
  end

endmodule

[sv/abip_core.sv]
// Scan state, accumulator update and result register of the parser.
// One character is consumed per step. Depends on abip_pkg, abip_decode.
module abip_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_valid,
  input  logic [7:0]                  step_char,
  input  logic                        step_last,
  output logic                        step_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [abip_pkg::ValueW-1:0] out_value
);

  localparam int unsigned W = abip_pkg::ValueW;

  abip_pkg::phase_t      phase, phase_next;
  logic [W-1:0]          acc, acc_next;
  logic                  neg, neg_next;
  logic [W-1:0]          res_acc;
  logic                  res_neg;
  abip_pkg::char_class_t cls;
  logic [W-1:0]          scaled;
  logic [W-1:0]          mac;
  logic [W-1:0]          digit_w;
  logic                  step_fire;

  abip_decode u_decode (
    .char_code (step_char),
    .cls       (cls)
  );

  assign step_ready = !step_last || !out_valid || out_ready;
  assign step_fire  = step_valid && step_ready;

  always_comb begin
    digit_w = {{(W-4){1'b0}}, cls.digit};
    case (phase)
      abip_pkg::PH_OCT: scaled = acc << 3;
      abip_pkg::PH_HEX: scaled = acc << 4;
      default:          scaled = (acc << 3) + (acc << 1);
    endcase
    mac = scaled + digit_w;
  end

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    neg_next   = neg;
    case (phase)
      abip_pkg::PH_BLANK1, abip_pkg::PH_BLANK2: begin
        if (cls.blank) begin
          phase_next = phase;
        end else if (cls.sign && phase == abip_pkg::PH_BLANK1) begin
          neg_next   = cls.minus;
          phase_next = abip_pkg::PH_BLANK2;
        end else if (cls.zero) begin
          acc_next   = '0;
          phase_next = abip_pkg::PH_ZERO;
        end else if (cls.dec) begin
          acc_next   = digit_w;
          phase_next = abip_pkg::PH_DEC;
        end else begin
          phase_next = abip_pkg::PH_DONE;
        end
      end
      abip_pkg::PH_ZERO: begin
        if (cls.hex_x) begin
          phase_next = abip_pkg::PH_HEX;
        end else if (cls.oct) begin
          acc_next   = digit_w;
          phase_next = abip_pkg::PH_OCT;
        end else begin
          phase_next = abip_pkg::PH_DONE;
        end
      end
      abip_pkg::PH_DEC: begin
        if (cls.dec) acc_next = mac;
        else         phase_next = abip_pkg::PH_DONE;
      end
      abip_pkg::PH_OCT: begin
        if (cls.oct) acc_next = mac;
        else         phase_next = abip_pkg::PH_DONE;
      end
      abip_pkg::PH_HEX: begin
        if (cls.hex) acc_next = mac;
        else         phase_next = abip_pkg::PH_DONE;
      end
      default: phase_next = abip_pkg::PH_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= abip_pkg::PH_BLANK1;
      acc       <= '0;
      neg       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (step_fire) begin
        if (step_last) begin
          phase     <= abip_pkg::PH_BLANK1;
          acc       <= '0;
          neg       <= 1'b0;
          out_valid <= 1'b1;
        end else begin
          phase <= phase_next;
          acc   <= acc_next;
          neg   <= neg_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && step_last) begin
      res_acc <= acc_next;
      res_neg <= neg_next;
    end
  end

  assign out_value = res_neg ? (~res_acc + {{(W-1){1'b0}}, 1'b1}) : res_acc;

`ifndef SYNTHESIS
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    step_fire && step_last |=> phase == abip_pkg::PH_BLANK1 && acc == '0 && !neg)
    else $error("state not cleared after last item");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    step_fire && step_last |=> out_valid)
    else $error("last item gave no result");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    step_fire && !step_last && phase == abip_pkg::PH_DONE
      |=> phase == abip_pkg::PH_DONE && $stable(acc))
    else $error("scan resumed after it stopped");

  a_blank_acc_zero: assert property (@(posedge clk) disable iff (rst)
    phase == abip_pkg::PH_BLANK1 || phase == abip_pkg::PH_BLANK2 |-> acc == '0)
    else $error("accumulator set before any digit");

  a_blank1_pos: assert property (@(posedge clk) disable iff (rst)
    phase == abip_pkg::PH_BLANK1 |-> !neg)
    else $error("sign set before sign phase");
`endif

endmodule

[sv/auto_base_integer_parser.sv]
// Auto-base integer parser: one character per item, value out on the last item.
// Result path: the last character passes the input and result registers.
// Throughput: one character per cycle, no gap between strings, if results drain.
// Stalls: the output register holds a result while the next string is taken in.
// Reset (rst, synchronous): clears valid flags, scan phase, accumulator and sign.
// Depends on abip_pkg, abip_ifs, abip_decode, abip_core.
module auto_base_integer_parser (
  input  logic                clk,
  input  logic                rst,
  abip_char_if.sink           text,
  abip_value_if.source        result
);

  // Input register: holds one character while the scan stage is busy
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;
  logic       step_ready;
  logic       core_valid;
  logic [abip_pkg::ValueW-1:0] core_value;

  // Take a new item whenever the register is empty or the held one moves on this cycle
  assign text.ready = !in_valid || step_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  // Payload needs no reset; load only on acceptance
  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_char <= text.char_code;
      in_last <= text.is_last;
    end
  end

  // Scan stage: phase, accumulator, sign and the result register
  abip_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step_valid (in_valid),
    .step_char  (in_char),
    .step_last  (in_last),
    .step_ready (step_ready),
    .out_valid  (core_valid),
    .out_ready  (result.ready),
    .out_value  (core_value)
  );

  assign result.valid        = core_valid;
  assign result.parsed_value = signed'(core_value);

endmodule
